### design/lrd_pkg.sv
// ----------------------------------------------------------------------------
// lrd_pkg: shared types and constants for the log record deframer
// Record header layout, status codes and the byte-wise reflected CRC-32 step.
// ----------------------------------------------------------------------------
package lrd_pkg;

  localparam int          HDR_LEN      = 7;
  localparam int          HC_W         = 3;
  localparam int          STORE_WORDS  = 3;
  localparam int          STORE_IDX_W  = 2;

  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [15:0] KV_BYTES     = 16'd24;

  localparam logic [1:0]  ST_ACCEPT    = 2'd0;
  localparam logic [1:0]  ST_CLEAN     = 2'd1;
  localparam logic [1:0]  ST_TORN      = 2'd2;
  localparam logic [1:0]  ST_MISMATCH  = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALTED  = 2'd2
  } phase_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### design/log_record_deframer_crc32_check.sv
// ----------------------------------------------------------------------------
// log_record_deframer_crc32_check: log record deframer with CRC-32 check
// Splits a byte stream into records, checks each CRC and emits key/value or
// end/mismatch status.
// ----------------------------------------------------------------------------
// Output: the result of an accepted request is registered into the output register.
// Throughput: one request per cycle while in_stall is low; the byte-wise CRC step
//   and record control sit between the state registers and the output register.
// in_stall rises only while a result is held in the output register under out_stall.
// Reset (synchronous, rst_n low) clears phase, counters, CRC, offsets and out_valid;
//   the payload store is not cleared and is always filled before it is read.
module log_record_deframer_crc32_check
  import lrd_pkg::*;
#(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_key_high,
  output logic [63:0] out_key_low,
  output logic [63:0] out_value_word,
  output logic [31:0] out_truncate_offset
);

  phase_t                  phase_r, phase_nxt;
  logic [HC_W-1:0]         hc_r, hc_nxt;
  logic [31:0]             exp_r, exp_nxt;
  logic [15:0]             plen_r, plen_nxt;
  logic [15:0]             pcnt_r, pcnt_nxt;
  logic [31:0]             crc_r, crc_nxt;
  logic [63:0]             store_r   [STORE_WORDS];
  logic [63:0]             store_nxt [STORE_WORDS];
  logic [OFFSET_WIDTH-1:0] so_r, so_nxt;
  logic [OFFSET_WIDTH-1:0] rs_r, rs_nxt;

  logic                    accept;
  logic                    fin;
  logic [STORE_IDX_W-1:0]  widx;
  logic                    res_valid;
  logic [1:0]              res_status;
  logic [63:0]             res_kh, res_kl, res_vw;
  logic [OFFSET_WIDTH-1:0] res_off;

  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic [63:0]             out_kh_r, out_kl_r, out_vw_r;
  logic [31:0]             out_off_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign widx     = pcnt_r[4:3];

  always_comb begin
    phase_nxt  = phase_r;
    hc_nxt     = hc_r;
    exp_nxt    = exp_r;
    plen_nxt   = plen_r;
    pcnt_nxt   = pcnt_r;
    crc_nxt    = crc_r;
    so_nxt     = so_r;
    rs_nxt     = rs_r;
    for (int w = 0; w < STORE_WORDS; w++) begin
      store_nxt[w] = store_r[w];
    end
    fin        = 1'b0;
    res_valid  = 1'b0;
    res_status = ST_CLEAN;
    res_kh     = '0;
    res_kl     = '0;
    res_vw     = '0;
    res_off    = rs_r;

    if (in_command) begin
      if (phase_r == PH_HEADER && hc_r == '0) begin
        res_valid  = 1'b1;
        res_status = ST_CLEAN;
      end else if (phase_r == PH_HEADER || phase_r == PH_PAYLOAD) begin
        res_valid  = 1'b1;
        res_status = ST_TORN;
      end
      phase_nxt = PH_HEADER;
      hc_nxt    = '0;
      exp_nxt   = '0;
      plen_nxt  = '0;
      pcnt_nxt  = '0;
      crc_nxt   = CRC_INIT;
      so_nxt    = '0;
      rs_nxt    = '0;
    end else begin
      so_nxt = so_r + OFFSET_WIDTH'(1);
      unique case (phase_r)
        PH_HEADER: begin
          if (hc_r < HC_W'(4)) begin
            exp_nxt = {exp_r[23:0], in_data_byte};
          end else begin
            if (hc_r < HC_W'(6)) begin
              plen_nxt = {plen_r[7:0], in_data_byte};
            end
            crc_nxt = crc_byte(crc_r, in_data_byte);
          end
          hc_nxt = hc_r + HC_W'(1);
          if (hc_r == HC_W'(HDR_LEN - 1)) begin
            hc_nxt    = '0;
            pcnt_nxt  = '0;
            phase_nxt = PH_PAYLOAD;
            fin       = (plen_nxt == '0);
          end
        end
        PH_PAYLOAD: begin
          if (pcnt_r < KV_BYTES) begin
            store_nxt[widx] = {store_r[widx][55:0], in_data_byte};
          end
          crc_nxt  = crc_byte(crc_r, in_data_byte);
          pcnt_nxt = pcnt_r + 16'd1;
          fin      = (pcnt_nxt == plen_r);
        end
        default: begin
        end
      endcase

      if (fin) begin
        if (~crc_nxt != exp_nxt) begin
          res_valid  = 1'b1;
          res_status = ST_MISMATCH;
          phase_nxt  = PH_HALTED;
        end else begin
          if (plen_nxt == KV_BYTES) begin
            res_valid  = 1'b1;
            res_status = ST_ACCEPT;
            res_kh     = store_nxt[0];
            res_kl     = store_nxt[1];
            res_vw     = store_nxt[2];
            res_off    = '0;
          end
          phase_nxt = PH_HEADER;
          hc_nxt    = '0;
          exp_nxt   = '0;
          plen_nxt  = '0;
          pcnt_nxt  = '0;
          crc_nxt   = CRC_INIT;
          rs_nxt    = so_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hc_r    <= '0;
      exp_r   <= '0;
      plen_r  <= '0;
      pcnt_r  <= '0;
      crc_r   <= CRC_INIT;
      so_r    <= '0;
      rs_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      exp_r   <= exp_nxt;
      plen_r  <= plen_nxt;
      pcnt_r  <= pcnt_nxt;
      crc_r   <= crc_nxt;
      so_r    <= so_nxt;
      rs_r    <= rs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int w = 0; w < STORE_WORDS; w++) begin
        store_r[w] <= store_nxt[w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_status_r <= res_status;
      out_kh_r     <= res_kh;
      out_kl_r     <= res_kl;
      out_vw_r     <= res_vw;
      out_off_r    <= 32'(res_off);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_key_high        = out_kh_r;
  assign out_key_low         = out_kl_r;
  assign out_value_word      = out_vw_r;
  assign out_truncate_offset = out_off_r;

endmodule

### design/lrd_checker.sv
// ----------------------------------------------------------------------------
// lrd_checker: port-level checks for the log record deframer
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module lrd_checker
  import lrd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [63:0] out_key_high,
  input logic [63:0] out_key_low,
  input logic [63:0] out_value_word,
  input logic [31:0] out_truncate_offset
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_truncate_offset) && $stable(out_key_high))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a held result");

  a_kv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ACCEPT |->
      out_key_high == '0 && out_key_low == '0 && out_value_word == '0)
    else $error("status result carries key or value data");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && !in_stall) && !(out_valid && out_stall) |=> !out_valid)
    else $error("result appeared without a request");

  a_accept_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ACCEPT |-> out_truncate_offset == '0)
    else $error("accepted record carries an offset");

endmodule

bind log_record_deframer_crc32_check lrd_checker u_lrd_checker (.*);
